FILE: rtl/apictd_pkg.sv
// ----------------------------------------------------------------------------
// APIC ID topology decode package
// Shared types and constants for the decode pipeline.
// ----------------------------------------------------------------------------
package apictd_pkg;

  localparam int unsigned DIV_W          = 15;
  localparam int unsigned STAGE_STEPS    = 5;
  localparam int unsigned NUM_DIV_STAGES = DIV_W / STAGE_STEPS;

  typedef enum logic [1:0] {
    MODE_THREAD_COUNT = 2'd0,
    MODE_MAX_ID       = 2'd1,
    MODE_UNSUPPORTED  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_VENDOR_MODE      = 3'd0,
    REG_CORE_FIELD_BITS  = 3'd1,
    REG_THREADS_PER_CORE = 3'd2,
    REG_MAX_LOGICAL_IDS  = 3'd3,
    REG_MAX_CORE_IDS     = 3'd4
  } reg_e;

  typedef struct packed {
    logic [1:0] vendor_mode;
    logic [3:0] core_field_bits;
    logic [4:0] threads_per_core;
    logic [7:0] max_logical_ids;
    logic [6:0] max_core_ids;
  } cfg_t;

  typedef struct packed {
    logic             div_en;
    logic             error;
    logic [4:0]       divisor;
    logic [DIV_W-1:0] num;
    logic [4:0]       rem;
    logic [7:0]       smt_id;
    logic [14:0]      core_id;
    logic [31:0]      package_id;
  } item_t;

endpackage

FILE: rtl/apictd_front.sv
// ----------------------------------------------------------------------------
// APIC ID topology decode front stage
// Masks the ID, splits the fields for the max-id mode and prepares the
// dividend and divisor for the thread-count mode.
// ----------------------------------------------------------------------------
module apictd_front #(
  parameter int unsigned APIC_ID_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  apictd_pkg::cfg_t   cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [31:0]        apic_id_i,
  output logic               valid_o,
  input  logic               ready_i,
  output apictd_pkg::item_t  item_o
);

  function automatic logic [31:0] low_mask(input logic [5:0] n);
    logic [31:0] m;
    if (n >= 6'd32) begin
      m = '1;
    end else begin
      m = (32'd1 << n) - 32'd1;
    end
    return m;
  endfunction

  logic [APIC_ID_WIDTH-1:0] id;
  logic [31:0]              id32;
  logic [6:0]               mc;
  logic [2:0]               cb;
  logic [3:0]               sb;
  logic [15:0]              lim;
  logic [4:0]               tpc;
  logic [31:0]              sh;
  logic [31:0]              cfb_mask;
  logic [31:0]              sb_mask;
  logic [31:0]              cb_mask;
  apictd_pkg::item_t        item_d;
  apictd_pkg::item_t        item_q;
  logic                     valid_q;

  assign id   = apic_id_i[APIC_ID_WIDTH-1:0];
  assign id32 = 32'(id);

  always_comb begin
    mc  = (cfg_i.max_core_ids == 7'd0) ? 7'd1 : cfg_i.max_core_ids;
    tpc = (cfg_i.threads_per_core == 5'd0) ? 5'd1 : cfg_i.threads_per_core;
    cb  = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (mc[i]) begin
        cb = 3'(i);
      end
    end
    sb  = 4'd8;
    lim = '0;
    for (int k = 8; k >= 0; k--) begin
      lim = (16'(mc) << k) + 16'(mc);
      if (16'(cfg_i.max_logical_ids) < lim) begin
        sb = 4'(k);
      end
    end
    sh       = id32 >> sb;
    cfb_mask = low_mask(6'(cfg_i.core_field_bits));
    sb_mask  = low_mask(6'(sb));
    cb_mask  = low_mask(6'(cb));
    item_d   = '0;
    case (cfg_i.vendor_mode)
      apictd_pkg::MODE_THREAD_COUNT: begin
        item_d.div_en     = 1'b1;
        item_d.divisor    = tpc;
        item_d.num        = id32[apictd_pkg::DIV_W-1:0]
                            & cfb_mask[apictd_pkg::DIV_W-1:0];
        item_d.package_id = id32 >> cfg_i.core_field_bits;
      end
      apictd_pkg::MODE_MAX_ID: begin
        item_d.divisor    = 5'd1;
        item_d.smt_id     = id32[7:0] & sb_mask[7:0];
        item_d.core_id    = sh[14:0] & cb_mask[14:0];
        item_d.package_id = id32 >> (5'(sb) + 5'(cb));
      end
      default: begin
        item_d.divisor = 5'd1;
        item_d.error   = 1'b1;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/apictd_div_stage.sv
// ----------------------------------------------------------------------------
// APIC ID topology decode divider stage
// One registered slice of a restoring divider, retiring a fixed number of
// quotient bits per stage.
// ----------------------------------------------------------------------------
module apictd_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  apictd_pkg::item_t  item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output apictd_pkg::item_t  item_o
);

  apictd_pkg::item_t item_d;
  apictd_pkg::item_t item_q;
  logic              valid_q;
  logic [5:0]        r6;
  logic              qbit;

  always_comb begin
    item_d = item_i;
    r6     = '0;
    qbit   = 1'b0;
    for (int i = 0; i < int'(apictd_pkg::STAGE_STEPS); i++) begin
      r6   = {item_d.rem, item_d.num[apictd_pkg::DIV_W-1]};
      qbit = (r6 >= {1'b0, item_d.divisor});
      item_d.rem = qbit ? 5'(r6 - {1'b0, item_d.divisor}) : r6[4:0];
      item_d.num = {item_d.num[apictd_pkg::DIV_W-2:0], qbit};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/apic_id_topology_decode.sv
// ----------------------------------------------------------------------------
// APIC ID topology decode
// Splits each APIC ID beat into thread, core and package numbers.
// ----------------------------------------------------------------------------
// The block takes one APIC ID per cycle when the output side keeps up and
// passes it through four register stages. The first stage masks the ID
// and cuts out the fields of the max-id mode; the thread-count mode then
// runs a fifteen-bit restoring division through three register stages of
// five steps each, and the last of them is the output register. An
// unsupported mode returns all fields zero with the error flag in tuser.
// Configuration registers sit at byte addresses 0, 4, 8, 12 and 16 and must
// be written only while no beat is in flight.
module apic_id_topology_decode #(
  parameter int unsigned APIC_ID_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] apic_id
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] smt_id, [22:8] core_id,
                                      // [54:23] package_id, [55] zero
  output logic [0:0]  m_axis_tuser    // [0] error
);

  apictd_pkg::cfg_t  cfg_q;
  apictd_pkg::reg_e  reg_idx;
  logic              cfg_we;

  logic              valid [apictd_pkg::NUM_DIV_STAGES+1];
  logic              ready [apictd_pkg::NUM_DIV_STAGES+1];
  apictd_pkg::item_t item  [apictd_pkg::NUM_DIV_STAGES+1];
  apictd_pkg::item_t last;

  assign reg_idx = apictd_pkg::reg_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vendor_mode      <= apictd_pkg::MODE_UNSUPPORTED;
      cfg_q.core_field_bits  <= 4'd0;
      cfg_q.threads_per_core <= 5'd1;
      cfg_q.max_logical_ids  <= 8'd1;
      cfg_q.max_core_ids     <= 7'd1;
    end else if (cfg_we) begin
      case (reg_idx)
        apictd_pkg::REG_VENDOR_MODE:      cfg_q.vendor_mode      <= pwdata[1:0];
        apictd_pkg::REG_CORE_FIELD_BITS:  cfg_q.core_field_bits  <= pwdata[3:0];
        apictd_pkg::REG_THREADS_PER_CORE: cfg_q.threads_per_core <= pwdata[4:0];
        apictd_pkg::REG_MAX_LOGICAL_IDS:  cfg_q.max_logical_ids  <= pwdata[7:0];
        apictd_pkg::REG_MAX_CORE_IDS:     cfg_q.max_core_ids     <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      apictd_pkg::REG_VENDOR_MODE:      prdata = 32'(cfg_q.vendor_mode);
      apictd_pkg::REG_CORE_FIELD_BITS:  prdata = 32'(cfg_q.core_field_bits);
      apictd_pkg::REG_THREADS_PER_CORE: prdata = 32'(cfg_q.threads_per_core);
      apictd_pkg::REG_MAX_LOGICAL_IDS:  prdata = 32'(cfg_q.max_logical_ids);
      apictd_pkg::REG_MAX_CORE_IDS:     prdata = 32'(cfg_q.max_core_ids);
      default:                          prdata = 32'd0;
    endcase
  end

  apictd_front #(
    .APIC_ID_WIDTH(APIC_ID_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .apic_id_i (s_axis_tdata),
    .valid_o   (valid[0]),
    .ready_i   (ready[0]),
    .item_o    (item[0])
  );

  for (genvar g = 0; g < int'(apictd_pkg::NUM_DIV_STAGES); g++) begin : g_div
    apictd_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[g]),
      .ready_o (ready[g]),
      .item_i  (item[g]),
      .valid_o (valid[g+1]),
      .ready_i (ready[g+1]),
      .item_o  (item[g+1])
    );
  end

  assign last  = item[apictd_pkg::NUM_DIV_STAGES];
  assign ready[apictd_pkg::NUM_DIV_STAGES] = m_axis_tready;

  assign m_axis_tvalid = valid[apictd_pkg::NUM_DIV_STAGES];
  assign m_axis_tdata  = {1'b0, last.package_id,
                          last.div_en ? last.num : last.core_id,
                          last.div_en ? 8'(last.rem) : last.smt_id};
  assign m_axis_tuser  = last.error;

endmodule

FILE: rtl/apictd_checker.sv
// ----------------------------------------------------------------------------
// APIC ID topology decode checker
// Port-level assertions on beat counts, stalls and error results.
// ----------------------------------------------------------------------------
module apictd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  localparam logic [2:0] Depth = 3'd4;

  logic [2:0] cnt_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 56'd0)
    else $error("error beat carries nonzero fields");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != 3'd0)
    else $error("output beat without a pending input beat");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Depth)
    else $error("more beats in flight than pipeline stages");

endmodule

bind apic_id_topology_decode apictd_checker u_apictd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/apic_id_topology_decode_tb.sv
// ----------------------------------------------------------------------------
// APIC ID topology decode testbench
// Drives APIC ID beats through the decoder under many register settings and
// checks every result beat against a predictor of the thread, core and
// package split. A directed table covers the extremes and the unsupported
// modes first, and random phases with random stalls on both sides follow.
// ----------------------------------------------------------------------------
module apic_id_topology_decode_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam int unsigned RANDOM_PHASES    = 30;
  localparam int unsigned ITEMS_PER_PHASE  = 60;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 150;

  typedef struct packed {
    logic [7:0]  smt_id;
    logic [14:0] core_id;
    logic [31:0] package_id;
    logic        error;
  } topo_t;

  typedef struct {
    apictd_pkg::cfg_t cfg;
    logic [31:0]      apic_id;
    bit               known;
    topo_t            topo;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] apic_id
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // [7:0] smt_id, [22:8] core_id,
                                    // [54:23] package_id, [55] zero
  logic [0:0]  m_axis_tuser;        // [0] error

  topo_t            pending_decodes[$];
  dir_row_t         dir_rows[$];
  apictd_pkg::cfg_t cur_cfg;
  int               mismatches = 0;
  int               tx_max_gap = 3;
  int               rx_max_gap = 3;
  int               rx_hold_cycles = 0;

  apic_id_topology_decode #(
    .APIC_ID_WIDTH(32)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned floor_log2(logic [31:0] v);
    int unsigned r;
    r = 0;
    while (v > 32'd1) begin
      v = v >> 1;
      r++;
    end
    return r;
  endfunction

  // Bits needed to hold values 0 .. v-1, zero when v is 0 or 1.
  function automatic int unsigned field_width(logic [31:0] v);
    int unsigned r;
    if (v <= 32'd1) return 0;
    r = floor_log2(v);
    if ((v & (v - 32'd1)) != 32'd0) r++;
    return r;
  endfunction

  function automatic topo_t decode_apic_id(apictd_pkg::cfg_t c, logic [31:0] id);
    topo_t       r;
    logic [31:0] divisor;
    logic [31:0] low;
    logic [31:0] cores;
    int unsigned thr_w;
    int unsigned core_w;
    r = '0;
    case (c.vendor_mode)
      apictd_pkg::MODE_THREAD_COUNT: begin
        divisor = (c.threads_per_core == 5'd0) ? 32'd1 : 32'(c.threads_per_core);
        low = id & ((32'd1 << c.core_field_bits) - 32'd1);
        r.package_id = id >> c.core_field_bits;
        r.core_id = 15'(low / divisor);
        r.smt_id = 8'(low % divisor);
      end
      apictd_pkg::MODE_MAX_ID: begin
        cores = (c.max_core_ids == 7'd0) ? 32'd1 : 32'(c.max_core_ids);
        thr_w = field_width(32'(c.max_logical_ids) / cores);
        core_w = floor_log2(cores);
        r.smt_id = 8'(id & ((32'd1 << thr_w) - 32'd1));
        r.core_id = 15'((id >> thr_w) & ((32'd1 << core_w) - 32'd1));
        r.package_id = id >> (thr_w + core_w);
      end
      default: begin
        r.error = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic apictd_pkg::cfg_t cfg_of(logic [1:0] mode, int cfb, int tpc,
                                              int mli, int mci);
    apictd_pkg::cfg_t c;
    c.vendor_mode = mode;
    c.core_field_bits = 4'(cfb);
    c.threads_per_core = 5'(tpc);
    c.max_logical_ids = 8'(mli);
    c.max_core_ids = 7'(mci);
    return c;
  endfunction

  function automatic topo_t topo_of(int thr, int core, logic [31:0] pkg, bit err);
    topo_t t;
    t.smt_id = 8'(thr);
    t.core_id = 15'(core);
    t.package_id = pkg;
    t.error = err;
    return t;
  endfunction

  function automatic void add_row(apictd_pkg::cfg_t c, logic [31:0] id, bit known,
                                  topo_t t);
    dir_row_t row;
    row.cfg = c;
    row.apic_id = id;
    row.known = known;
    row.topo = t;
    dir_rows.push_back(row);
  endfunction

  function automatic apictd_pkg::cfg_t random_cfg();
    apictd_pkg::cfg_t c;
    int unsigned      pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) c.vendor_mode = apictd_pkg::MODE_THREAD_COUNT;
    else if (pick < 8) c.vendor_mode = apictd_pkg::MODE_MAX_ID;
    else if (pick == 8) c.vendor_mode = apictd_pkg::MODE_UNSUPPORTED;
    else c.vendor_mode = MODE_RESERVED;
    c.core_field_bits = 4'($urandom_range(0, 15));
    c.threads_per_core = 5'($urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(0, 31));
    c.max_logical_ids = 8'($urandom_range(0, 255));
    c.max_core_ids = 7'($urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(0, 127));
    return c;
  endfunction

  function automatic logic [31:0] random_apic_id();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 255));
      1: return 32'($urandom_range(0, 65535));
      2: return $urandom | 32'hFFFF_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic apb_write(apictd_pkg::reg_e idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Waits until the decoder has handed back every beat it took in.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(apictd_pkg::cfg_t c);
    drain();
    apb_write(apictd_pkg::REG_VENDOR_MODE, 32'(c.vendor_mode));
    apb_write(apictd_pkg::REG_CORE_FIELD_BITS, 32'(c.core_field_bits));
    apb_write(apictd_pkg::REG_THREADS_PER_CORE, 32'(c.threads_per_core));
    apb_write(apictd_pkg::REG_MAX_LOGICAL_IDS, 32'(c.max_logical_ids));
    apb_write(apictd_pkg::REG_MAX_CORE_IDS, 32'(c.max_core_ids));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic send_apic_id(logic [31:0] id, bit known, topo_t t);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= id;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_decodes.push_back(known ? t : decode_apic_id(cur_cfg, id));
  endtask

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    mismatches++;
    $display("%0t: %s expected %0h, got %0h", $realtime, name, exp_v, got_v);
  endtask

  task automatic check_result();
    topo_t exp_t;
    if (pending_decodes.size() == 0) begin
      mismatches++;
      $display("%0t: result beat with nothing expected, got tdata %0h tuser %0h",
               $realtime, m_axis_tdata, m_axis_tuser);
      return;
    end
    exp_t = pending_decodes.pop_front();
    if (m_axis_tdata[7:0] !== exp_t.smt_id)
      report_field("smt_id", 32'(exp_t.smt_id), 32'(m_axis_tdata[7:0]));
    if (m_axis_tdata[22:8] !== exp_t.core_id)
      report_field("core_id", 32'(exp_t.core_id), 32'(m_axis_tdata[22:8]));
    if (m_axis_tdata[54:23] !== exp_t.package_id)
      report_field("package_id", exp_t.package_id, m_axis_tdata[54:23]);
    if (m_axis_tdata[55] !== 1'b0)
      report_field("tdata pad", 32'd0, 32'(m_axis_tdata[55]));
    if (m_axis_tuser[0] !== exp_t.error)
      report_field("error", 32'(exp_t.error), 32'(m_axis_tuser[0]));
  endtask

  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = (rx_hold_cycles > 0) ? rx_hold_cycles : $urandom_range(0, rx_max_gap);
      rx_hold_cycles = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_result();
    end
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    topo_t none;
    none = '0;
    cur_cfg = cfg_of(apictd_pkg::MODE_UNSUPPORTED, 0, 1, 1, 1);

    add_row(cur_cfg, 32'hFFFF_FFFF, 1, topo_of(0, 0, 32'h0, 1));
    add_row(cur_cfg, 32'h0000_0000, 1, topo_of(0, 0, 32'h0, 1));
    add_row(cfg_of(MODE_RESERVED, 15, 31, 255, 127), 32'h8000_0001, 1,
            topo_of(0, 0, 32'h0, 1));
    add_row(cfg_of(apictd_pkg::MODE_THREAD_COUNT, 0, 1, 1, 1), 32'hFFFF_FFFF, 1,
            topo_of(0, 0, 32'hFFFF_FFFF, 0));
    add_row(cfg_of(apictd_pkg::MODE_THREAD_COUNT, 0, 1, 1, 1), 32'h0000_0000, 1,
            topo_of(0, 0, 32'h0, 0));
    add_row(cfg_of(apictd_pkg::MODE_THREAD_COUNT, 15, 0, 0, 0), 32'hFFFF_FFFF, 1,
            topo_of(0, 'h7FFF, 32'h0001_FFFF, 0));
    add_row(cfg_of(apictd_pkg::MODE_THREAD_COUNT, 15, 16, 0, 0), 32'h0000_7FFF, 1,
            topo_of(15, 'h7FF, 32'h0, 0));
    add_row(cfg_of(apictd_pkg::MODE_THREAD_COUNT, 15, 31, 0, 0), 32'h0000_7FFF, 0, none);
    add_row(cfg_of(apictd_pkg::MODE_THREAD_COUNT, 8, 3, 0, 0), 32'h1234_5678, 0, none);
    add_row(cfg_of(apictd_pkg::MODE_THREAD_COUNT, 4, 17, 0, 0), 32'hDEAD_BEEF, 0, none);
    add_row(cfg_of(apictd_pkg::MODE_MAX_ID, 0, 1, 0, 0), 32'hFFFF_FFFF, 1,
            topo_of(0, 0, 32'hFFFF_FFFF, 0));
    add_row(cfg_of(apictd_pkg::MODE_MAX_ID, 0, 1, 255, 1), 32'hFFFF_FFFF, 1,
            topo_of('hFF, 0, 32'h00FF_FFFF, 0));
    add_row(cfg_of(apictd_pkg::MODE_MAX_ID, 0, 1, 255, 0), 32'hFFFF_FFFF, 1,
            topo_of('hFF, 0, 32'h00FF_FFFF, 0));
    add_row(cfg_of(apictd_pkg::MODE_MAX_ID, 0, 1, 255, 64), 32'hFFFF_FFFF, 0, none);
    add_row(cfg_of(apictd_pkg::MODE_MAX_ID, 0, 1, 0, 127), 32'hA5A5_A5A5, 0, none);
    add_row(cfg_of(apictd_pkg::MODE_MAX_ID, 0, 1, 8, 8), 32'hFFFF_FFFF, 0, none);
    add_row(cfg_of(apictd_pkg::MODE_MAX_ID, 0, 1, 255, 127), 32'h0000_00FF, 0, none);
    add_row(cfg_of(apictd_pkg::MODE_MAX_ID, 0, 1, 128, 2), 32'h5555_5555, 0, none);
    add_row(cfg_of(apictd_pkg::MODE_MAX_ID, 0, 1, 3, 1), 32'h0000_0007, 0, none);
    add_row(cfg_of(apictd_pkg::MODE_UNSUPPORTED, 15, 31, 255, 127), 32'h0000_0001, 1,
            topo_of(0, 0, 32'h0, 1));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != cur_cfg) set_config(dir_rows[i].cfg);
      send_apic_id(dir_rows[i].apic_id, dir_rows[i].known, dir_rows[i].topo);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) set_config(cfg_of(apictd_pkg::MODE_THREAD_COUNT, 15, 31, 255, 127));
      else if (ph == 1) set_config(cfg_of(apictd_pkg::MODE_MAX_ID, 0, 0, 255, 127));
      else if (ph == 2) set_config(cfg_of(apictd_pkg::MODE_THREAD_COUNT, 0, 0, 0, 0));
      else set_config(random_cfg());
      tx_max_gap = (ph % 3 == 0) ? 0 : 12;
      rx_max_gap = (ph % 4 == 1) ? 0 : 12;
      if (ph == 4) begin
        tx_max_gap = 0;
        rx_hold_cycles = LONG_HOLD_CYCLES;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 7 && n == ITEMS_PER_PHASE / 2) drain();
        send_apic_id(random_apic_id(), 0, none);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: apic_id_topology_decode.f
rtl/apictd_pkg.sv
rtl/apictd_front.sv
rtl/apictd_div_stage.sv
rtl/apic_id_topology_decode.sv
rtl/apictd_checker.sv
tb/apic_id_topology_decode_tb.sv
